// File: hw/rtl/solpq_pkg.sv
// shared constants and types for the sorted open-list priority queue
package solpq_pkg;

	localparam int DEF_CAPACITY    = 64;
	localparam int DEF_COST_BITS   = 16;
	localparam int DEF_COORD_BITS  = 8;
	localparam int DEF_HANDLE_BITS = 8;

	localparam int OP_W = 3;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	typedef struct packed {
		logic            eval;
		logic            commit;
		logic [OP_W-1:0] op;
	} ctl_t;

endpackage

// File: hw/rtl/solpq_in_if.sv
// request channel: operation and key fields
interface solpq_in_if
	import solpq_pkg::*;
#(
	parameter int COST_BITS   = DEF_COST_BITS,
	parameter int COORD_BITS  = DEF_COORD_BITS,
	parameter int HANDLE_BITS = DEF_HANDLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        op;
	logic [COST_BITS-1:0]   cost;
	logic [COORD_BITS-1:0]  x;
	logic [COORD_BITS-1:0]  y;
	logic [HANDLE_BITS-1:0] handle;

	modport source (output valid, op, cost, x, y, handle, input ready);
	modport sink (input valid, op, cost, x, y, handle, output ready);
endinterface

// File: hw/rtl/solpq_out_if.sv
// result channel: status, entry fields and occupancy
interface solpq_out_if
	import solpq_pkg::*;
#(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int COST_BITS   = DEF_COST_BITS,
	parameter int COORD_BITS  = DEF_COORD_BITS,
	parameter int HANDLE_BITS = DEF_HANDLE_BITS,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
);
	logic                   valid;
	logic                   ready;
	logic                   ok;
	logic                   full_error;
	logic [COST_BITS-1:0]   out_cost;
	logic [COORD_BITS-1:0]  out_x;
	logic [COORD_BITS-1:0]  out_y;
	logic [HANDLE_BITS-1:0] out_handle;
	logic                   is_empty;
	logic [CNT_W-1:0]       entry_total;

	modport source (output valid, ok, full_error, out_cost, out_x, out_y, out_handle,
		is_empty, entry_total, input ready);
	modport sink (input valid, ok, full_error, out_cost, out_x, out_y, out_handle,
		is_empty, entry_total, output ready);
endinterface

// File: hw/rtl/sorted_open_list_priority_queue_top.sv
// Sorted open-list priority queue: a row of CAPACITY cells keeps entries in ascending
// cost order, equal costs in arrival order. A request is accepted, every cell compares
// its entry with the key in the next cycle, and then, in the shift cycle, the whole row
// shifts at once and the result beat is registered. The next request can be accepted in
// that same shift cycle, so a new request is taken while the last one is being committed.
// The shift cycle waits while the result register is still held. There is no clearing
// pass after reset.
module sorted_open_list_priority_queue_top
	import solpq_pkg::*;
#(
	parameter int CAPACITY    = DEF_CAPACITY,
	parameter int COST_BITS   = DEF_COST_BITS,
	parameter int COORD_BITS  = DEF_COORD_BITS,
	parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	solpq_in_if.sink    in_ch,
	solpq_out_if.source out_ch
);

	localparam int ENTRY_W = COST_BITS + 2 * COORD_BITS + HANDLE_BITS;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam logic [CAPACITY-1:0] VEC_ONE = CAPACITY'(1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EVAL   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0]             state_q;
	logic [OP_W-1:0]        op_s1;
	logic [COST_BITS-1:0]   cost_s1;
	logic [COORD_BITS-1:0]  x_s1;
	logic [COORD_BITS-1:0]  y_s1;
	logic [HANDLE_BITS-1:0] handle_s1;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_nxt;

	logic                   out_valid_q;
	logic                   ok_q;
	logic                   full_q;
	logic [COST_BITS-1:0]   out_cost_q;
	logic [COORD_BITS-1:0]  out_x_q;
	logic [COORD_BITS-1:0]  out_y_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic                   empty_q;
	logic [CNT_W-1:0]       total_q;

	logic                   out_free;
	logic                   fire;
	logic                   accept;
	logic                   full;
	ctl_t                   ctl;

	logic [ENTRY_W-1:0]     entry_w [CAPACITY];
	logic [CAPACITY-1:0]    valid_w;
	logic [CAPACITY-1:0]    cond_w;
	logic [CAPACITY-1:0]    hit_w;
	logic [CAPACITY-1:0]    first_w;
	logic [CAPACITY-1:0]    below_w;
	logic [CAPACITY-1:0]    gone_w;
	logic                   any_hit;
	logic [ENTRY_W-1:0]     found;
	logic [ENTRY_W-1:0]     res_entry;
	logic                   res_ok;

	assign out_free = !out_valid_q || out_ch.ready;
	assign fire     = (state_q == S_COMMIT) && out_free;
	assign in_ch.ready = (state_q == S_IDLE) || fire;
	assign accept   = in_ch.valid && in_ch.ready;
	assign full     = (count_q == CNT_W'(CAPACITY));

	assign ctl.eval   = (state_q == S_EVAL);
	assign ctl.commit = fire && !((op_s1 == OP_INSERT) && full);
	assign ctl.op     = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (fire) begin
						state_q <= accept ? S_EVAL : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= in_ch.op;
			cost_s1   <= in_ch.cost;
			x_s1      <= in_ch.x;
			y_s1      <= in_ch.y;
			handle_s1 <= in_ch.handle;
		end
	end

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ENTRY_W-1:0] prev_entry;
		logic               prev_valid;
		logic               prev_cond;
		logic [ENTRY_W-1:0] next_entry;
		logic               next_valid;

		if (i == 0) begin : g_head
			assign prev_entry = '0;
			assign prev_valid = 1'b0;
			assign prev_cond  = 1'b0;
		end else begin : g_mid
			assign prev_entry = entry_w[i-1];
			assign prev_valid = valid_w[i-1];
			assign prev_cond  = cond_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_entry = '0;
			assign next_valid = 1'b0;
		end else begin : g_body
			assign next_entry = entry_w[i+1];
			assign next_valid = valid_w[i+1];
		end

		solpq_cell #(
			.COST_BITS  (COST_BITS),
			.COORD_BITS (COORD_BITS),
			.HANDLE_BITS(HANDLE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key_cost  (cost_s1),
			.key_x     (x_s1),
			.key_y     (y_s1),
			.key_handle(handle_s1),
			.prev_entry(prev_entry),
			.prev_valid(prev_valid),
			.prev_cond (prev_cond),
			.next_entry(next_entry),
			.next_valid(next_valid),
			.gone      (gone_w[i]),
			.entry     (entry_w[i]),
			.valid     (valid_w[i]),
			.cond      (cond_w[i]),
			.hit       (hit_w[i])
		);
	end

	// first hit and everything from it toward the tail
	assign any_hit = |hit_w;
	assign first_w = hit_w & (~hit_w + VEC_ONE);
	assign below_w = (hit_w ^ (hit_w - VEC_ONE)) >> 1;
	assign gone_w  = any_hit ? ~below_w : '0;

	always_comb begin
		found = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found = found | (first_w[i] ? entry_w[i] : '0);
		end
	end

	always_comb begin
		count_nxt = count_q;
		res_ok    = 1'b0;
		res_entry = '0;
		case (op_s1)
			OP_INSERT: begin
				if (!full) begin
					count_nxt = count_q + CNT_W'(1);
					res_ok    = 1'b1;
				end
			end
			OP_POP: begin
				if (valid_w[0]) begin
					count_nxt = count_q - CNT_W'(1);
					res_ok    = 1'b1;
					res_entry = entry_w[0];
				end
			end
			OP_FIND: begin
				res_ok    = any_hit;
				res_entry = found;
			end
			OP_DELETE: begin
				if (any_hit) begin
					count_nxt = count_q - CNT_W'(1);
					res_ok    = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ok_q    <= res_ok;
			full_q  <= (op_s1 == OP_INSERT) && full;
			{out_cost_q, out_x_q, out_y_q, out_handle_q} <= res_entry;
			empty_q <= (count_nxt == '0);
			total_q <= count_nxt;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.ok          = ok_q;
	assign out_ch.full_error  = full_q;
	assign out_ch.out_cost    = out_cost_q;
	assign out_ch.out_x       = out_x_q;
	assign out_ch.out_y       = out_y_q;
	assign out_ch.out_handle  = out_handle_q;
	assign out_ch.is_empty    = empty_q;
	assign out_ch.entry_total = total_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("occupied cells disagree with entry count");

	a_eval_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |=> state_q == S_COMMIT)
		else $error("compare cycle not followed by shift cycle");

	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(ok_q && full_q))
		else $error("result beat both accepted and refused");
`endif

endmodule

// File: hw/rtl/solpq_cell.sv
// one queue slot: holds an entry, compares it with the key, shifts with its neighbors
module solpq_cell
	import solpq_pkg::*;
#(
	parameter int COST_BITS   = DEF_COST_BITS,
	parameter int COORD_BITS  = DEF_COORD_BITS,
	parameter int HANDLE_BITS = DEF_HANDLE_BITS,
	localparam int ENTRY_W    = COST_BITS + 2 * COORD_BITS + HANDLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_t                   ctl,
	input  logic [COST_BITS-1:0]   key_cost,
	input  logic [COORD_BITS-1:0]  key_x,
	input  logic [COORD_BITS-1:0]  key_y,
	input  logic [HANDLE_BITS-1:0] key_handle,
	input  logic [ENTRY_W-1:0]     prev_entry,
	input  logic                   prev_valid,
	input  logic                   prev_cond,
	input  logic [ENTRY_W-1:0]     next_entry,
	input  logic                   next_valid,
	input  logic                   gone,
	output logic [ENTRY_W-1:0]     entry,
	output logic                   valid,
	output logic                   cond,
	output logic                   hit
);

	logic [ENTRY_W-1:0]     entry_q;
	logic                   valid_q;
	logic                   cond_s2;
	logic                   hit_s2;
	logic [COST_BITS-1:0]   cur_cost;
	logic [COORD_BITS-1:0]  cur_x;
	logic [COORD_BITS-1:0]  cur_y;
	logic [HANDLE_BITS-1:0] cur_tag;
	logic [ENTRY_W-1:0]     nxt_entry;
	logic                   nxt_valid;

	assign {cur_cost, cur_x, cur_y, cur_tag} = entry_q;

	// compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cond_s2 <= 1'b0;
			hit_s2  <= 1'b0;
		end else if (ctl.eval) begin
			cond_s2 <= !valid_q || (cur_cost > key_cost);
			if (ctl.op == OP_FIND) begin
				hit_s2 <= valid_q && (cur_x == key_x) && (cur_y == key_y);
			end else begin
				hit_s2 <= valid_q && (cur_tag == key_handle);
			end
		end
	end

	always_comb begin
		nxt_entry = entry_q;
		nxt_valid = valid_q;
		case (ctl.op)
			OP_INSERT: begin
				if (prev_cond && cond_s2) begin
					nxt_entry = prev_entry;
					nxt_valid = prev_valid;
				end else if (cond_s2) begin
					nxt_entry = {key_cost, key_x, key_y, key_handle};
					nxt_valid = 1'b1;
				end
			end
			OP_POP: begin
				nxt_entry = next_entry;
				nxt_valid = next_valid;
			end
			OP_DELETE: begin
				if (gone) begin
					nxt_entry = next_entry;
					nxt_valid = next_valid;
				end
			end
			OP_CLEAR: begin
				nxt_valid = 1'b0;
			end
			default: begin
				nxt_valid = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.commit) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			entry_q <= nxt_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign cond  = cond_s2;
	assign hit   = hit_s2;

endmodule

// File: tb/tb_sorted_open_list_priority_queue_top.sv
// testbench for the sorted open-list priority queue: queued requests, live prediction, checks
module tb_sorted_open_list_priority_queue_top;
	import solpq_pkg::*;

	localparam int CNT_W = $clog2(DEF_CAPACITY + 1);
	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;

	// op codes with no function in the block
	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]            op;
		logic [DEF_COST_BITS-1:0]   cost;
		logic [DEF_COORD_BITS-1:0]  x;
		logic [DEF_COORD_BITS-1:0]  y;
		logic [DEF_HANDLE_BITS-1:0] handle;
	} request_t;

	typedef struct packed {
		logic [DEF_COST_BITS-1:0]   cost;
		logic [DEF_COORD_BITS-1:0]  x;
		logic [DEF_COORD_BITS-1:0]  y;
		logic [DEF_HANDLE_BITS-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic                       ok;
		logic                       full_error;
		logic [DEF_COST_BITS-1:0]   cost;
		logic [DEF_COORD_BITS-1:0]  x;
		logic [DEF_COORD_BITS-1:0]  y;
		logic [DEF_HANDLE_BITS-1:0] handle;
		logic                       is_empty;
		logic [CNT_W-1:0]           entry_total;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	solpq_in_if  in_ch ();
	solpq_out_if out_ch ();

	sorted_open_list_priority_queue_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #4 clk = ~clk;

	request_t request_fifo[$];
	reply_t   pending_replies[$];
	entry_t   open_list[$];

	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned hold_req_id;
	int unsigned hold_seen;
	int unsigned hold_cnt;

	function automatic void predict_reply(request_t r);
		reply_t rep;
		entry_t e;
		int pos;
		rep = '0;
		case (r.op)
			OP_INSERT: begin
				if (open_list.size() >= DEF_CAPACITY) begin
					rep.full_error = 1'b1;
				end else begin
					pos = 0;
					while (pos < open_list.size() && open_list[pos].cost <= r.cost)
						pos++;
					e.cost = r.cost;
					e.x = r.x;
					e.y = r.y;
					e.handle = r.handle;
					open_list.insert(pos, e);
					rep.ok = 1'b1;
				end
			end
			OP_POP: begin
				if (open_list.size() != 0) begin
					e = open_list.pop_front();
					rep.ok = 1'b1;
					rep.cost = e.cost;
					rep.x = e.x;
					rep.y = e.y;
					rep.handle = e.handle;
				end
			end
			OP_FIND: begin
				for (int i = 0; i < open_list.size(); i++) begin
					if (open_list[i].x == r.x && open_list[i].y == r.y) begin
						rep.ok = 1'b1;
						rep.cost = open_list[i].cost;
						rep.x = open_list[i].x;
						rep.y = open_list[i].y;
						rep.handle = open_list[i].handle;
						break;
					end
				end
			end
			OP_DELETE: begin
				for (int i = 0; i < open_list.size(); i++) begin
					if (open_list[i].handle == r.handle) begin
						open_list.delete(i);
						rep.ok = 1'b1;
						break;
					end
				end
			end
			OP_CLEAR: begin
				open_list.delete();
			end
			default: begin
			end
		endcase
		rep.is_empty = (open_list.size() == 0);
		rep.entry_total = CNT_W'(open_list.size());
		pending_replies.push_back(rep);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
			mismatch_cnt++;
		end
	endfunction

	function automatic request_t rand_request();
		request_t r;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40)
			r.op = OP_INSERT;
		else if (roll < 60)
			r.op = OP_POP;
		else if (roll < 75)
			r.op = OP_FIND;
		else if (roll < 90)
			r.op = OP_DELETE;
		else if (roll < 93)
			r.op = OP_CLEAR;
		else
			r.op = OP_W'($urandom_range(OP_SPARE_7, OP_SPARE_5));
		r.cost = DEF_COST_BITS'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(31));
		r.x = DEF_COORD_BITS'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(7));
		r.y = DEF_COORD_BITS'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(7));
		r.handle = DEF_HANDLE_BITS'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(15));
		return r;
	endfunction

	task automatic queue_req(logic [OP_W-1:0] op, int unsigned cost, int unsigned x,
			int unsigned y, int unsigned handle);
		request_t r;
		r.op = op;
		r.cost = DEF_COST_BITS'(cost);
		r.x = DEF_COORD_BITS'(x);
		r.y = DEF_COORD_BITS'(y);
		r.handle = DEF_HANDLE_BITS'(handle);
		request_fifo.push_back(r);
	endtask

	task automatic drain();
		while (request_fifo.size() != 0 || in_ch.valid || pending_replies.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.op <= '0;
			in_ch.cost <= '0;
			in_ch.x <= '0;
			in_ch.y <= '0;
			in_ch.handle <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				r.op = in_ch.op;
				r.cost = in_ch.cost;
				r.x = in_ch.x;
				r.y = in_ch.y;
				r.handle = in_ch.handle;
				predict_reply(r);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (request_fifo.size() != 0 && $urandom_range(99) >= gap_pct) begin
					r = request_fifo.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.op <= r.op;
					in_ch.cost <= r.cost;
					in_ch.x <= r.x;
					in_ch.y <= r.y;
					in_ch.handle <= r.handle;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 0;
			hold_cnt <= 0;
		end else if (hold_req_id != hold_seen) begin
			hold_seen <= hold_req_id;
			hold_cnt <= HOLD_CYCLES;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result beat: expected none actual ok=%0b total=%0d",
					$time, out_ch.ok, out_ch.entry_total);
				mismatch_cnt++;
			end else begin
				want = pending_replies.pop_front();
				check_field("ok", 32'(want.ok), 32'(out_ch.ok));
				check_field("full_error", 32'(want.full_error), 32'(out_ch.full_error));
				check_field("out_cost", 32'(want.cost), 32'(out_ch.out_cost));
				check_field("out_x", 32'(want.x), 32'(out_ch.out_x));
				check_field("out_y", 32'(want.y), 32'(out_ch.out_y));
				check_field("out_handle", 32'(want.handle), 32'(out_ch.out_handle));
				check_field("is_empty", 32'(want.is_empty), 32'(out_ch.is_empty));
				check_field("entry_total", 32'(want.entry_total), 32'(out_ch.entry_total));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("** sorted_open_list_priority_queue_top: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = '0;
		in_ch.cost = '0;
		in_ch.x = '0;
		in_ch.y = '0;
		in_ch.handle = '0;
		out_ch.ready = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		hold_req_id = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty store, extremes, ties, duplicates, spare ops
		queue_req(OP_POP, 0, 0, 0, 0);
		queue_req(OP_FIND, 0, 255, 255, 0);
		queue_req(OP_DELETE, 0, 0, 0, 255);
		queue_req(OP_INSERT, 65535, 255, 255, 255);
		queue_req(OP_INSERT, 0, 0, 0, 0);
		queue_req(OP_INSERT, 100, 1, 2, 7);
		queue_req(OP_INSERT, 100, 3, 4, 7);
		queue_req(OP_INSERT, 100, 1, 2, 9);
		queue_req(OP_FIND, 0, 1, 2, 0);
		queue_req(OP_FIND, 0, 9, 9, 0);
		queue_req(OP_DELETE, 0, 0, 0, 7);
		queue_req(OP_DELETE, 0, 0, 0, 200);
		queue_req(OP_POP, 0, 0, 0, 0);
		queue_req(OP_POP, 0, 0, 0, 0);
		queue_req(OP_SPARE_5, 0, 0, 0, 0);
		queue_req(OP_SPARE_6, 16'h5555, 8'haa, 8'h55, 8'haa);
		queue_req(OP_SPARE_7, 65535, 255, 255, 255);
		queue_req(OP_CLEAR, 0, 0, 0, 0);
		queue_req(OP_POP, 0, 0, 0, 0);
		queue_req(OP_INSERT, 16'h5555, 8'haa, 8'h55, 8'haa);
		queue_req(OP_INSERT, 16'haaaa, 8'h55, 8'haa, 8'h55);
		queue_req(OP_FIND, 0, 8'haa, 8'h55, 0);
		queue_req(OP_CLEAR, 0, 0, 0, 0);
		drain();

		// fill past capacity with the receiver held off, no idling
		queue_req(OP_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < 70; i++)
			queue_req(OP_INSERT, $urandom_range(15), $urandom_range(7), $urandom_range(7),
				$urandom_range(15));
		for (int i = 0; i < 30; i++)
			request_fifo.push_back(rand_request());
		hold_req_id++;
		drain();

		gap_pct = 88;
		stall_pct = 0;
		for (int i = 0; i < 100; i++)
			request_fifo.push_back(rand_request());
		drain();

		gap_pct = 0;
		stall_pct = 88;
		for (int i = 0; i < 100; i++)
			request_fifo.push_back(rand_request());
		drain();

		gap_pct = 11;
		stall_pct = 11;
		for (int i = 0; i < 100; i++)
			request_fifo.push_back(rand_request());
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("** sorted_open_list_priority_queue_top: PASSED **");
		else
			$display("** sorted_open_list_priority_queue_top: FAILED **");
		$finish;
	end

endmodule
